@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file qbi_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QBI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QBI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/qbi_pkg.sv @@
// ----------------------------------------------------------------------------
// qbi_pkg
// Shared widths, register codes, reset values and result types.
// ----------------------------------------------------------------------------
package qbi_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DELTA_W = 16;
  localparam int TIME_W  = 16;

  localparam logic [CFG_W-1:0] REPORT_INTERVAL_RST = 16'd10;
  localparam logic [CFG_W-1:0] TIME_PRESCALE_RST   = 16'd1;
  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;

  // direction per {last state, new dt}: set = count up
  localparam logic [7:0] DIR_MASK = 8'h66;

  localparam logic signed [DELTA_W-1:0] ACC_MAX = 16'sh7FFF;
  localparam logic signed [DELTA_W-1:0] ACC_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_INTERVAL = 2'd0,
    CFG_TIME_PRESCALE   = 2'd1,
    CFG_DEBOUNCE_TIME   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] elapsed;
  } btn_status_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      pressed;
    logic [TIME_W-1:0]         elapsed;
  } result_t;

endpackage

@@ hdl/qbi_button.sv @@
// ----------------------------------------------------------------------------
// qbi_button
// Prescaled elapsed-time counter and two-sample button debounce.
// ----------------------------------------------------------------------------
module qbi_button #(
  parameter int COUNT_WIDTH = qbi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          level_i,
  input  logic [qbi_pkg::CFG_W-1:0]     time_prescale_i,
  input  logic [qbi_pkg::CFG_W-1:0]     debounce_time_i,
  output qbi_pkg::btn_status_t          status_o
);

  localparam int CmpW = (COUNT_WIDTH > qbi_pkg::CFG_W) ? COUNT_WIDTH : qbi_pkg::CFG_W;

  logic [COUNT_WIDTH-1:0]        prescale_q, prescale_d, pc_bump, pc_new;
  logic [qbi_pkg::TIME_W-1:0]    elapsed_q, elapsed_d, el_inc, el_new;
  logic                          prior_q, prior_d, pressed_q, pressed_d;
  logic                          unit_tick, sample_en, sample, flip;
  logic                          prior_new, pressed_new;

  always_comb begin
    pc_bump   = (prescale_q == '1) ? prescale_q : prescale_q + COUNT_WIDTH'(1);
    unit_tick = CmpW'(pc_bump) >= CmpW'(time_prescale_i);
    pc_new    = unit_tick ? '0 : pc_bump;
    el_inc    = (unit_tick && elapsed_q != '1) ? elapsed_q + qbi_pkg::TIME_W'(1)
                                               : elapsed_q;
    // sample only once the settle time has run out
    sample_en   = el_inc >= debounce_time_i;
    sample      = ~level_i;
    flip        = sample_en && (sample == prior_q) && (sample != pressed_q);
    el_new      = flip ? '0 : el_inc;
    pressed_new = flip ? sample : pressed_q;
    prior_new   = sample_en ? sample : prior_q;

    prescale_d = accept_i ? pc_new      : prescale_q;
    elapsed_d  = accept_i ? el_new      : elapsed_q;
    prior_d    = accept_i ? prior_new   : prior_q;
    pressed_d  = accept_i ? pressed_new : pressed_q;

    status_o.pressed = pressed_new;
    status_o.elapsed = el_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      elapsed_q  <= '0;
      prior_q    <= 1'b0;
      pressed_q  <= 1'b0;
    end else begin
      prescale_q <= prescale_d;
      elapsed_q  <= elapsed_d;
      prior_q    <= prior_d;
      pressed_q  <= pressed_d;
    end
  end

endmodule

@@ hdl/qbi_encoder.sv @@
// ----------------------------------------------------------------------------
// qbi_encoder
// Quadrature transition decode into a saturating signed step accumulator.
// ----------------------------------------------------------------------------
module qbi_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                enc_dt_i,
  input  logic                                enc_clk_i,
  input  logic                                report_i,
  output logic signed [qbi_pkg::DELTA_W-1:0]  delta_o
);

  logic [1:0]                         last_q, last_d, now_st, diff;
  logic signed [qbi_pkg::DELTA_W-1:0] accum_q, accum_d, acc_new;
  logic                               single, up;

  always_comb begin
    now_st  = {enc_dt_i, enc_clk_i};
    diff    = now_st ^ last_q;
    single  = (diff == 2'b01) || (diff == 2'b10);
    up      = qbi_pkg::DIR_MASK[{last_q, now_st[1]}];
    acc_new = accum_q;
    if (single) begin
      if (up) begin
        if (accum_q != qbi_pkg::ACC_MAX) acc_new = accum_q + 16'sd1;
      end else begin
        if (accum_q != qbi_pkg::ACC_MIN) acc_new = accum_q - 16'sd1;
      end
    end
    // a report hands the count out and restarts from zero
    accum_d = accept_i ? (report_i ? '0 : acc_new) : accum_q;
    last_d  = accept_i ? now_st : last_q;
    delta_o = acc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      accum_q <= '0;
    end else begin
      last_q  <= last_d;
      accum_q <= accum_d;
    end
  end

endmodule

@@ hdl/qbi_outbuf.sv @@
// ----------------------------------------------------------------------------
// qbi_outbuf
// Output register with one skid entry; decouples out_ready from in_ready.
// ----------------------------------------------------------------------------
module qbi_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qbi_pkg::result_t  push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qbi_pkg::result_t  out_data_o
);

  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  qbi_pkg::result_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      // output stalled: park the new request
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/quadrature_and_button_input.sv @@
// ----------------------------------------------------------------------------
// quadrature_and_button_input
// Quadrature encoder decoder and debounced button with periodic reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one request per sampling tick with
//   the encoder pins enc_dt_i, enc_clk_i and the active-low button_level_i.
//   Output channel (out_valid_o/out_ready_i): one report every
//   report_interval ticks with the net position delta, the debounced button
//   state and its elapsed time, all reflecting the reporting tick itself.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 report_interval,
//   1 time_prescale, 2 debounce_time; index 3 is ignored. Always ready;
//   write only while no request is in flight.
// Timing:
//   One request per cycle while in_ready_o is high. All state updates in
//   the accepting cycle; a report is registered in the output register.
// Stall:
//   An output register plus one skid entry. in_ready_o drops only when a
//   report is parked in the skid entry, i.e. after a report arrived while
//   the output was stalled; it returns the cycle after the output drains.
// Reset:
//   Counters, accumulator and button state clear to zero (not pressed);
//   registers return to 10 / 1 / 50. No reports pending.
// ----------------------------------------------------------------------------
module quadrature_and_button_input #(
  parameter int COUNT_WIDTH = qbi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qbi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [qbi_pkg::CFG_W-1:0]           cfg_data_i,
  // tick requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                enc_dt_i,
  input  logic                                enc_clk_i,
  input  logic                                button_level_i,
  // reports
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qbi_pkg::DELTA_W-1:0]  position_delta_o,
  output logic                                button_pressed_o,
  output logic [qbi_pkg::TIME_W-1:0]          button_time_o
);

  localparam int CmpW = (COUNT_WIDTH > qbi_pkg::CFG_W) ? COUNT_WIDTH : qbi_pkg::CFG_W;

  logic [qbi_pkg::CFG_W-1:0] report_interval_q, time_prescale_q, debounce_time_q;
  logic [COUNT_WIDTH-1:0]    report_cnt_q, report_cnt_d, rc_bump;
  logic                      accept, report;
  logic signed [qbi_pkg::DELTA_W-1:0] delta;
  qbi_pkg::btn_status_t      btn_status;
  qbi_pkg::result_t          result, out_data;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i & in_ready_o;

  // Config registers; unused index drops the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_interval_q <= qbi_pkg::REPORT_INTERVAL_RST;
      time_prescale_q   <= qbi_pkg::TIME_PRESCALE_RST;
      debounce_time_q   <= qbi_pkg::DEBOUNCE_TIME_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (qbi_pkg::cfg_idx_e'(cfg_index_i))
        qbi_pkg::CFG_REPORT_INTERVAL: report_interval_q <= cfg_data_i;
        qbi_pkg::CFG_TIME_PRESCALE:   time_prescale_q   <= cfg_data_i;
        qbi_pkg::CFG_DEBOUNCE_TIME:   debounce_time_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Report tick counter: saturating bump, fires at >= interval
  // (an interval of zero reports every tick).
  always_comb begin
    rc_bump      = (report_cnt_q == '1) ? report_cnt_q : report_cnt_q + COUNT_WIDTH'(1);
    report       = CmpW'(rc_bump) >= CmpW'(report_interval_q);
    report_cnt_d = accept ? (report ? '0 : rc_bump) : report_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_cnt_q <= '0;
    end else begin
      report_cnt_q <= report_cnt_d;
    end
  end

  qbi_button #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_button (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .level_i         (button_level_i),
    .time_prescale_i (time_prescale_q),
    .debounce_time_i (debounce_time_q),
    .status_o        (btn_status)
  );

  qbi_encoder u_encoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .enc_dt_i  (enc_dt_i),
    .enc_clk_i (enc_clk_i),
    .report_i  (report),
    .delta_o   (delta)
  );

  // report carries both the encoder and the button updates of this tick
  always_comb begin
    result.delta   = delta;
    result.pressed = btn_status.pressed;
    result.elapsed = btn_status.elapsed;
  end

  qbi_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & report),
    .push_data_i (result),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign position_delta_o = out_data.delta;
  assign button_pressed_o = out_data.pressed;
  assign button_time_o    = out_data.elapsed;

endmodule

@@ hdl/qbi_checker.sv @@
// ----------------------------------------------------------------------------
// qbi_checker
// Port-level checks for the encoder/button block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qbi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [qbi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input logic [qbi_pkg::CFG_W-1:0]           cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                enc_dt_i,
  input logic                                enc_clk_i,
  input logic                                button_level_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [qbi_pkg::DELTA_W-1:0]  position_delta_o,
  input logic                                button_pressed_o,
  input logic [qbi_pkg::TIME_W-1:0]          button_time_o
);

  logic out_stall;
  assign out_stall = out_valid_o & ~out_ready_i;

  // a stalled report stays offered
  `QBI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)

  // and keeps its payload
  `QBI_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(position_delta_o) && $stable(button_pressed_o) && $stable(button_time_o))

  // back-pressure only with a full output register
  `QBI_ASSERT_IMP(a_bp_full, clk_i, rst_ni, !in_ready_o, out_valid_o)

  // back-pressure only follows a stalled output
  `QBI_ASSERT_IMP(a_bp_cause, clk_i, rst_ni, !in_ready_o, $past(out_stall))

endmodule

bind quadrature_and_button_input qbi_checker u_qbi_checker (.*);
